// File: design/shae_pkg.sv
// Package with the SHA-256 constants and the round and schedule functions.
package shae_pkg;

    // Geometry of the block buffer and of the digest.
    localparam int BLOCK_BYTES  = 64;
    localparam int BLOCK_BITS   = BLOCK_BYTES * 8;
    localparam int LEN_START    = 56;
    localparam int ROUNDS       = 64;
    localparam int HASH_WORDS   = 8;
    localparam int TOTAL_W      = 61;

    // Padding marker byte.
    localparam logic [7:0] PAD_MARKER = 8'h80;

    // Round constants.
    localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash values.
    localparam logic [31:0] HASH_IV [0:HASH_WORDS-1] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Compression function sigma on the a word.
    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Compression function sigma on the e word.
    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Message schedule sigma on w[t-15].
    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Message schedule sigma on w[t-2].
    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// File: design/sha256_hash_engine_unit.sv
// SHA-256 engine over a byte stream with a single shared round datapath.

// Message bytes are taken one per cycle while data_ready is high. When a byte completes
// a 64-byte block, the block is compressed by one round datapath that runs one round per
// cycle, through 64 rounds and then a step that folds the result into the hash words;
// data_ready is low meanwhile. The message schedule lives in the block buffer itself, a
// 512-bit shift line that slides one word per round. An end of message inserts the
// padding one byte per cycle from the current fill level up to 64, with one or two
// compressions, and then presents the digest as four 64-bit big-endian words, most
// significant first; a request is held until taken. After the fourth word the hash
// words return to the initial values and data_ready rises.
module sha256_hash_engine_unit
    import shae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROUND  = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_PAD    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    localparam int FILL_W  = $clog2(BLOCK_BYTES);
    localparam int ROUND_W = $clog2(ROUNDS);

    logic [2:0]            state_reg, state_next;
    logic [ROUND_W-1:0]    round_reg, round_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  eom_pend_reg, eom_pend_next;
    logic                  marker_reg, marker_next;
    logic                  final_reg, final_next;
    logic [1:0]            word_reg, word_next;
    logic [31:0]           hash_reg [0:HASH_WORDS-1];
    logic [31:0]           hash_next [0:HASH_WORDS-1];
    logic [31:0]           wv_reg [0:HASH_WORDS-1];
    logic [31:0]           wv_next [0:HASH_WORDS-1];
    logic [BLOCK_BITS-1:0] buf_reg, buf_next;

    // Round datapath signals.
    logic [31:0] w_t;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch_val;
    logic [31:0] maj_val;
    logic [63:0] len_bits;
    logic [7:0]  pad_byte;
    logic [2:0]  len_idx;

    // Handshake and result ports.
    assign data_ready   = (state_reg == S_IDLE);
    assign digest_valid = (state_reg == S_OUT);
    assign digest_word  = {hash_reg[0], hash_reg[1]};
    assign word_index   = word_reg;
    assign last_word    = (word_reg == 2'd3);

    // Message schedule: the window holds w[t] .. w[t+15], w[t] in the top word.
    assign w_t   = buf_reg[BLOCK_BITS-1 -: 32];
    assign w_new = w_t + small_sigma0(buf_reg[BLOCK_BITS-33 -: 32])
                 + buf_reg[BLOCK_BITS-1-9*32 -: 32]
                 + small_sigma1(buf_reg[BLOCK_BITS-1-14*32 -: 32]);

    // One compression round on the working variables.
    assign ch_val  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign maj_val = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                   ^ (wv_reg[1] & wv_reg[2]);
    assign t1 = wv_reg[7] + big_sigma1(wv_reg[4]) + ch_val + ROUND_K[round_reg] + w_t;
    assign t2 = big_sigma0(wv_reg[0]) + maj_val;

    // Padding byte: marker first, then zeros, then the bit length in the last eight.
    assign len_bits = {total_reg, 3'b000};
    assign len_idx  = ~fill_reg[2:0];
    always_comb
    begin
        if (!marker_reg)
        begin
            pad_byte = PAD_MARKER;
        end
        else if (final_reg && (fill_reg >= FILL_W'(LEN_START)))
        begin
            pad_byte = len_bits[{len_idx, 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        fill_next     = fill_reg;
        total_next    = total_reg;
        eom_pend_next = eom_pend_reg;
        marker_next   = marker_reg;
        final_next    = final_reg;
        word_next     = word_reg;
        buf_next      = buf_reg;
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            hash_next[i] = hash_reg[i];
            wv_next[i]   = wv_reg[i];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (data_valid)
                begin
                    if (byte_present)
                    begin
                        buf_next   = {buf_reg[BLOCK_BITS-9:0], data_byte};
                        fill_next  = fill_reg + 1'b1;
                        total_next = total_reg + 1'b1;
                        if (fill_reg == FILL_W'(BLOCK_BYTES - 1))
                        begin
                            // Block complete: compress, then pad if the message ended.
                            eom_pend_next = end_of_message;
                            round_next    = '0;
                            state_next    = S_ROUND;
                            for (int i = 0; i < HASH_WORDS; i++)
                            begin
                                wv_next[i] = hash_reg[i];
                            end
                        end
                        else if (end_of_message)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end

            S_ROUND:
            begin
                buf_next   = {buf_reg[BLOCK_BITS-33:0], w_new};
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_next[i] = hash_reg[i] + wv_reg[i];
                end
                if (final_reg)
                begin
                    word_next  = '0;
                    state_next = S_OUT;
                end
                else if (marker_reg)
                begin
                    // Marker did not leave room for the length: one more block.
                    final_next = 1'b1;
                    state_next = S_PAD;
                end
                else if (eom_pend_reg)
                begin
                    eom_pend_next = 1'b0;
                    state_next    = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_PAD:
            begin
                buf_next  = {buf_reg[BLOCK_BITS-9:0], pad_byte};
                fill_next = fill_reg + 1'b1;
                if (!marker_reg)
                begin
                    marker_next = 1'b1;
                    final_next  = (fill_reg < FILL_W'(LEN_START));
                end
                if (fill_reg == FILL_W'(BLOCK_BYTES - 1))
                begin
                    round_next = '0;
                    state_next = S_ROUND;
                    for (int i = 0; i < HASH_WORDS; i++)
                    begin
                        wv_next[i] = hash_reg[i];
                    end
                end
            end

            S_OUT:
            begin
                if (digest_ready)
                begin
                    word_next = word_reg + 1'b1;
                    if (word_reg == 2'd3)
                    begin
                        // Last word taken: start the next message.
                        for (int i = 0; i < HASH_WORDS; i++)
                        begin
                            hash_next[i] = HASH_IV[i];
                        end
                        fill_next   = '0;
                        total_next  = '0;
                        marker_next = 1'b0;
                        final_next  = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        // Slide the next pair of hash words to the output.
                        for (int i = 0; i < HASH_WORDS - 2; i++)
                        begin
                            hash_next[i] = hash_reg[i + 2];
                        end
                        hash_next[HASH_WORDS-2] = hash_reg[0];
                        hash_next[HASH_WORDS-1] = hash_reg[1];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and hash words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            round_reg    <= '0;
            fill_reg     <= '0;
            total_reg    <= '0;
            eom_pend_reg <= 1'b0;
            marker_reg   <= 1'b0;
            final_reg    <= 1'b0;
            word_reg     <= '0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                hash_reg[i] <= HASH_IV[i];
            end
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            fill_reg     <= fill_next;
            total_reg    <= total_next;
            eom_pend_reg <= eom_pend_next;
            marker_reg   <= marker_next;
            final_reg    <= final_next;
            word_reg     <= word_next;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                hash_reg[i] <= hash_next[i];
            end
        end
    end

    // Block buffer and working variables carry no reset.
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            wv_reg[i] <= wv_next[i];
        end
    end

    // The input side and the result side are never open together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(data_ready && digest_valid))
        else $error("input and digest requests open at the same time");

    // Rounds advance one per cycle while compressing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) && (round_reg != ROUND_W'(ROUNDS - 1))
        |=> (state_reg == S_ROUND) && (round_reg == $past(round_reg) + 1'b1))
        else $error("round counter skipped while compressing");

    // After the final word the message state starts empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && last_word
        |=> data_ready && (fill_reg == '0) && (total_reg == '0) && !marker_reg)
        else $error("message state not cleared after the digest");

endmodule
